// ===== hdl/forth_dual_stack_unit_assert.svh =====
// Assertion macros used by the stack unit datapath RTL.
`ifndef FORTH_DUAL_STACK_UNIT_ASSERT_SVH
`define FORTH_DUAL_STACK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fsd_pkg.sv =====
`default_nettype none

package fsd_pkg;

  localparam int unsigned DATA_STACK_DEPTH   = 32;
  localparam int unsigned RETURN_STACK_DEPTH = 32;
  localparam int unsigned VALUE_WIDTH        = 32;

  localparam int unsigned CMD_W   = 5;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned TAG_W   = 2;
  localparam int unsigned PV_W    = 32;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned RDSEL_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH      = 5'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR_RS  = 5'd2;
  localparam logic [CMD_W-1:0] CMD_EMPTY     = 5'd3;
  localparam logic [CMD_W-1:0] CMD_DEPTH     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_DUP       = 5'd5;
  localparam logic [CMD_W-1:0] CMD_SWAP      = 5'd6;
  localparam logic [CMD_W-1:0] CMD_SWAP_RS   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_OVER      = 5'd8;
  localparam logic [CMD_W-1:0] CMD_PICK      = 5'd9;
  localparam logic [CMD_W-1:0] CMD_REPLACE   = 5'd10;
  localparam logic [CMD_W-1:0] CMD_TWO_DUP   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_DROP      = 5'd12;
  localparam logic [CMD_W-1:0] CMD_TWO_DROP  = 5'd13;
  localparam logic [CMD_W-1:0] CMD_THREE_DROP= 5'd14;
  localparam logic [CMD_W-1:0] CMD_DROP_RS   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_TWO_DROP_RS = 5'd16;
  localparam logic [CMD_W-1:0] CMD_ROT       = 5'd17;
  localparam logic [CMD_W-1:0] CMD_INV_ROT   = 5'd18;
  localparam logic [CMD_W-1:0] CMD_TO_R      = 5'd19;
  localparam logic [CMD_W-1:0] CMD_TWO_TO_R  = 5'd20;
  localparam logic [CMD_W-1:0] CMD_COPY_TO_R = 5'd21;
  localparam logic [CMD_W-1:0] CMD_FROM_R    = 5'd22;
  localparam logic [CMD_W-1:0] CMD_TWO_FROM_R= 5'd23;
  localparam logic [CMD_W-1:0] CMD_COPY_FROM_R = 5'd24;

  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_DUNDER  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_RUNDER  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NOTINT  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NEG     = 3'd5;
  localparam logic [ERR_W-1:0] ERR_DOVER   = 3'd6;
  localparam logic [ERR_W-1:0] ERR_ROVER   = 3'd7;

  localparam logic [TAG_W-1:0] TAG_INT  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_BOOL = 2'd2;

  // Read selects for the stack memories.
  localparam logic [RDSEL_W-1:0] RD_TOP0 = 3'd0;
  localparam logic [RDSEL_W-1:0] RD_TOP1 = 3'd1;
  localparam logic [RDSEL_W-1:0] RD_TOP2 = 3'd2;
  localparam logic [RDSEL_W-1:0] RD_PICK = 3'd3;
  localparam logic [RDSEL_W-1:0] RD_VIEW = 3'd4;

  typedef struct packed {
    logic               load;
    logic [RDSEL_W-1:0] rd_sel;
    logic               cap0;
    logic               cap1;
    logic               cap2;
    logic               exec;
    logic               wr_en;
    logic [1:0]         wr_slot;
    logic               out_load;
  } fsd_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/fsd_ram.sv =====
`default_nettype none

module fsd_ram #(
  parameter int unsigned Width = 34,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/fsd_datapath.sv =====
`default_nettype none

`include "forth_dual_stack_unit_assert.svh"

module fsd_datapath #(
  parameter int unsigned DataDepth   = fsd_pkg::DATA_STACK_DEPTH,
  parameter int unsigned ReturnDepth = fsd_pkg::RETURN_STACK_DEPTH,
  parameter int unsigned ValueWidth  = fsd_pkg::VALUE_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fsd_pkg::fsd_ctrl_t                ctrl_i,
  input  wire logic        [fsd_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic signed [fsd_pkg::PV_W-1:0]   push_value_i,
  input  wire logic        [fsd_pkg::TAG_W-1:0]  push_tag_i,
  output logic             [fsd_pkg::ERR_W-1:0]  error_code_o,
  output logic signed      [fsd_pkg::PV_W-1:0]   top_value_o,
  output logic             [fsd_pkg::TAG_W-1:0]  top_tag_o,
  output logic             [fsd_pkg::DEPTH_W-1:0] data_depth_o,
  output logic             [fsd_pkg::DEPTH_W-1:0] return_depth_o
);

  localparam int unsigned CW  = $clog2(DataDepth + 1);
  localparam int unsigned RCW = $clog2(ReturnDepth + 1);
  localparam int unsigned AW  = $clog2(DataDepth);
  localparam int unsigned RAW = $clog2(ReturnDepth);
  localparam int unsigned EW  = ValueWidth + fsd_pkg::TAG_W;
  localparam int unsigned XW  = ValueWidth + CW;
  localparam int unsigned PW  = fsd_pkg::PV_W;
  localparam int unsigned DW  = fsd_pkg::DEPTH_W;

  logic [fsd_pkg::CMD_W-1:0] cmd_q;
  logic [EW-1:0]  pcell_q;
  logic [EW-1:0]  d0_q, d1_q, d2_q, r0_q, r1_q;
  logic [CW-1:0]  dcnt_q, dcnt_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic [fsd_pkg::ERR_W-1:0] err_q, err_d;

  logic [AW-1:0]  dwa_q [3];
  logic [AW-1:0]  dwa_d [3];
  logic [EW-1:0]  dwd_q [3];
  logic [EW-1:0]  dwd_d [3];
  logic [2:0]     dwe_q, dwe_d;
  logic [RAW-1:0] rwa_q [2];
  logic [RAW-1:0] rwa_d [2];
  logic [EW-1:0]  rwd_q [2];
  logic [EW-1:0]  rwd_d [2];
  logic [1:0]     rwe_q, rwe_d;

  logic [AW-1:0]  d_raddr;
  logic [RAW-1:0] r_raddr;
  logic [EW-1:0]  d_rdata, r_rdata;
  logic           d_we, r_we;

  logic [CW-1:0]  dm1, dm2, dm3, dp1, dp2, pick_a, repl_a;
  logic [RCW-1:0] rm1, rm2, rp1, rp2;
  logic [XW-1:0]  ix_ext, dc_ext;
  logic [CW-1:0]  ix_n;
  logic [EW-1:0]  empty_cell, depth_cell;
  logic [ValueWidth+PW-1:0] pv_ext;
  logic [ValueWidth-1:0]    top_v;
  logic [ValueWidth+PW-1:0] top_ext;

  assign dm1 = dcnt_q - CW'(1);
  assign dm2 = dcnt_q - CW'(2);
  assign dm3 = dcnt_q - CW'(3);
  assign dp1 = dcnt_q + CW'(1);
  assign dp2 = dcnt_q + CW'(2);
  assign rm1 = rcnt_q - RCW'(1);
  assign rm2 = rcnt_q - RCW'(2);
  assign rp1 = rcnt_q + RCW'(1);
  assign rp2 = rcnt_q + RCW'(2);

  assign ix_ext = {{CW{1'b0}}, d0_q[EW-1:fsd_pkg::TAG_W]};
  assign ix_n   = ix_ext[CW-1:0];
  assign pick_a = dm2 - ix_n;
  assign repl_a = dm3 - ix_n;
  assign dc_ext = {{ValueWidth{1'b0}}, dcnt_q};

  assign empty_cell = {{(ValueWidth-1){1'b0}}, (dcnt_q == '0), fsd_pkg::TAG_BOOL};
  assign depth_cell = {dc_ext[ValueWidth-1:0], fsd_pkg::TAG_INT};
  assign pv_ext     = {{ValueWidth{push_value_i[PW-1]}}, push_value_i};

  function automatic logic [fsd_pkg::ERR_W-1:0] chk_index(
    input logic [EW-1:0] ix,
    input logic [XW-1:0] ixv,
    input logic [CW-1:0] below
  );
    logic [XW-1:0] b_ext;
    b_ext = {{ValueWidth{1'b0}}, below};
    if (ix[fsd_pkg::TAG_W-1:0] != fsd_pkg::TAG_INT) begin
      return fsd_pkg::ERR_NOTINT;
    end else if (ix[EW-1]) begin
      return fsd_pkg::ERR_NEG;
    end else if (ixv >= b_ext) begin
      return fsd_pkg::ERR_RANGE;
    end
    return fsd_pkg::ERR_OK;
  endfunction

  always_comb begin
    case (ctrl_i.rd_sel)
      fsd_pkg::RD_TOP1: d_raddr = dm2[AW-1:0];
      fsd_pkg::RD_TOP2: d_raddr = dm3[AW-1:0];
      fsd_pkg::RD_PICK: d_raddr = pick_a[AW-1:0];
      default:          d_raddr = dm1[AW-1:0];
    endcase
    case (ctrl_i.rd_sel)
      fsd_pkg::RD_TOP1: r_raddr = rm2[RAW-1:0];
      default:          r_raddr = rm1[RAW-1:0];
    endcase
  end

  assign d_we = ctrl_i.wr_en && dwe_q[ctrl_i.wr_slot];
  assign r_we = ctrl_i.wr_en && (ctrl_i.wr_slot != 2'd2) && rwe_q[ctrl_i.wr_slot[0]];

  fsd_ram #(.Width(EW), .Depth(DataDepth)) u_dram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (dwa_q[ctrl_i.wr_slot]),
    .wdata_i (dwd_q[ctrl_i.wr_slot]),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  fsd_ram #(.Width(EW), .Depth(ReturnDepth)) u_rram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (rwa_q[ctrl_i.wr_slot[0]]),
    .wdata_i (rwd_q[ctrl_i.wr_slot[0]]),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  always_comb begin
    logic du1, du2, du3, ru1, ru2, dov1, dov2, rov1, rov2;
    du1  = dcnt_q < CW'(1);
    du2  = dcnt_q < CW'(2);
    du3  = dcnt_q < CW'(3);
    ru1  = rcnt_q < RCW'(1);
    ru2  = rcnt_q < RCW'(2);
    dov1 = dcnt_q > CW'(DataDepth - 1);
    dov2 = dcnt_q > CW'(DataDepth - 2);
    rov1 = rcnt_q > RCW'(ReturnDepth - 1);
    rov2 = rcnt_q > RCW'(ReturnDepth - 2);
    err_d  = fsd_pkg::ERR_OK;
    dcnt_d = dcnt_q;
    rcnt_d = rcnt_q;
    dwe_d  = '0;
    rwe_d  = '0;
    for (int i = 0; i < 3; i++) begin
      dwa_d[i] = dcnt_q[AW-1:0];
      dwd_d[i] = d0_q;
    end
    for (int i = 0; i < 2; i++) begin
      rwa_d[i] = rcnt_q[RAW-1:0];
      rwd_d[i] = d0_q;
    end
    case (cmd_q)
      fsd_pkg::CMD_PUSH, fsd_pkg::CMD_EMPTY, fsd_pkg::CMD_DEPTH: begin
        if (dov1) begin
          err_d = fsd_pkg::ERR_DOVER;
        end else begin
          dwe_d[0] = 1'b1;
          dwd_d[0] = (cmd_q == fsd_pkg::CMD_PUSH)  ? pcell_q :
                     (cmd_q == fsd_pkg::CMD_EMPTY) ? empty_cell : depth_cell;
          dcnt_d = dp1;
        end
      end
      fsd_pkg::CMD_CLEAR:    dcnt_d = '0;
      fsd_pkg::CMD_CLEAR_RS: rcnt_d = '0;
      fsd_pkg::CMD_DUP, fsd_pkg::CMD_OVER: begin
        if ((cmd_q == fsd_pkg::CMD_DUP) ? du1 : du2) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else if (dov1) begin
          err_d = fsd_pkg::ERR_DOVER;
        end else begin
          dwe_d[0] = 1'b1;
          dwd_d[0] = (cmd_q == fsd_pkg::CMD_DUP) ? d0_q : d1_q;
          dcnt_d = dp1;
        end
      end
      fsd_pkg::CMD_SWAP: begin
        if (du2) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else begin
          dwe_d[1:0] = 2'b11;
          dwa_d[0] = dm1[AW-1:0];
          dwd_d[0] = d1_q;
          dwa_d[1] = dm2[AW-1:0];
          dwd_d[1] = d0_q;
        end
      end
      fsd_pkg::CMD_SWAP_RS: begin
        if (ru2) begin
          err_d = fsd_pkg::ERR_RUNDER;
        end else begin
          rwe_d = 2'b11;
          rwa_d[0] = rm1[RAW-1:0];
          rwd_d[0] = r1_q;
          rwa_d[1] = rm2[RAW-1:0];
          rwd_d[1] = r0_q;
        end
      end
      fsd_pkg::CMD_PICK: begin
        if (du1) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else begin
          err_d = chk_index(d0_q, ix_ext, dm1);
          if (err_d == fsd_pkg::ERR_OK) begin
            dwe_d[0] = 1'b1;
            dwa_d[0] = dm1[AW-1:0];
            dwd_d[0] = d_rdata;
          end
        end
      end
      fsd_pkg::CMD_REPLACE: begin
        if (du2) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else begin
          err_d = chk_index(d0_q, ix_ext, dm2);
          if (err_d == fsd_pkg::ERR_OK) begin
            dwe_d[0] = 1'b1;
            dwa_d[0] = repl_a[AW-1:0];
            dwd_d[0] = d1_q;
            dcnt_d = dm2;
          end
        end
      end
      fsd_pkg::CMD_TWO_DUP: begin
        if (du2) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else if (dov2) begin
          err_d = fsd_pkg::ERR_DOVER;
        end else begin
          dwe_d[1:0] = 2'b11;
          dwd_d[0] = d1_q;
          dwa_d[1] = dp1[AW-1:0];
          dwd_d[1] = d0_q;
          dcnt_d = dp2;
        end
      end
      fsd_pkg::CMD_DROP: begin
        if (du1) err_d = fsd_pkg::ERR_DUNDER;
        else dcnt_d = dm1;
      end
      fsd_pkg::CMD_TWO_DROP: begin
        if (du2) err_d = fsd_pkg::ERR_DUNDER;
        else dcnt_d = dm2;
      end
      fsd_pkg::CMD_THREE_DROP: begin
        if (du3) err_d = fsd_pkg::ERR_DUNDER;
        else dcnt_d = dm3;
      end
      fsd_pkg::CMD_DROP_RS: begin
        if (ru1) err_d = fsd_pkg::ERR_RUNDER;
        else rcnt_d = rm1;
      end
      fsd_pkg::CMD_TWO_DROP_RS: begin
        if (ru2) err_d = fsd_pkg::ERR_RUNDER;
        else rcnt_d = rm2;
      end
      fsd_pkg::CMD_ROT, fsd_pkg::CMD_INV_ROT: begin
        if (du3) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else begin
          dwe_d = 3'b111;
          dwa_d[0] = dm3[AW-1:0];
          dwa_d[1] = dm2[AW-1:0];
          dwa_d[2] = dm1[AW-1:0];
          if (cmd_q == fsd_pkg::CMD_ROT) begin
            dwd_d[0] = d1_q;
            dwd_d[1] = d0_q;
            dwd_d[2] = d2_q;
          end else begin
            dwd_d[0] = d0_q;
            dwd_d[1] = d2_q;
            dwd_d[2] = d1_q;
          end
        end
      end
      fsd_pkg::CMD_TO_R, fsd_pkg::CMD_COPY_TO_R: begin
        if (du1) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else if (rov1) begin
          err_d = fsd_pkg::ERR_ROVER;
        end else begin
          rwe_d[0] = 1'b1;
          rcnt_d = rp1;
          if (cmd_q == fsd_pkg::CMD_TO_R) dcnt_d = dm1;
        end
      end
      fsd_pkg::CMD_TWO_TO_R: begin
        if (du2) begin
          err_d = fsd_pkg::ERR_DUNDER;
        end else if (rov2) begin
          err_d = fsd_pkg::ERR_ROVER;
        end else begin
          rwe_d = 2'b11;
          rwa_d[1] = rp1[RAW-1:0];
          rwd_d[1] = d1_q;
          rcnt_d = rp2;
          dcnt_d = dm2;
        end
      end
      fsd_pkg::CMD_FROM_R, fsd_pkg::CMD_COPY_FROM_R: begin
        if (ru1) begin
          err_d = fsd_pkg::ERR_RUNDER;
        end else if (dov1) begin
          err_d = fsd_pkg::ERR_DOVER;
        end else begin
          dwe_d[0] = 1'b1;
          dwd_d[0] = r0_q;
          dcnt_d = dp1;
          if (cmd_q == fsd_pkg::CMD_FROM_R) rcnt_d = rm1;
        end
      end
      fsd_pkg::CMD_TWO_FROM_R: begin
        if (ru2) begin
          err_d = fsd_pkg::ERR_RUNDER;
        end else if (dov2) begin
          err_d = fsd_pkg::ERR_DOVER;
        end else begin
          dwe_d[1:0] = 2'b11;
          dwd_d[0] = r0_q;
          dwa_d[1] = dp1[AW-1:0];
          dwd_d[1] = r1_q;
          dcnt_d = dp2;
          rcnt_d = rm2;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
      rcnt_q <= '0;
      dwe_q  <= '0;
      rwe_q  <= '0;
    end else if (ctrl_i.exec) begin
      dcnt_q <= dcnt_d;
      rcnt_q <= rcnt_d;
      dwe_q  <= dwe_d;
      rwe_q  <= rwe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      pcell_q <= {pv_ext[ValueWidth-1:0], push_tag_i};
    end
    if (ctrl_i.cap0) begin
      d0_q <= d_rdata;
      r0_q <= r_rdata;
    end
    if (ctrl_i.cap1) begin
      d1_q <= d_rdata;
      r1_q <= r_rdata;
    end
    if (ctrl_i.cap2) begin
      d2_q <= d_rdata;
    end
    if (ctrl_i.exec) begin
      err_q <= err_d;
      dwa_q <= dwa_d;
      dwd_q <= dwd_d;
      rwa_q <= rwa_d;
      rwd_q <= rwd_d;
    end
  end

  assign top_v   = d_rdata[EW-1:fsd_pkg::TAG_W];
  assign top_ext = {{PW{top_v[ValueWidth-1]}}, top_v};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      error_code_o   <= err_q;
      top_value_o    <= (dcnt_q != '0) ? top_ext[PW-1:0] : '0;
      top_tag_o      <= (dcnt_q != '0) ? d_rdata[fsd_pkg::TAG_W-1:0] : '0;
      data_depth_o   <= DW'(dcnt_q);
      return_depth_o <= DW'(rcnt_q);
    end
  end

  `FSD_ASSERT_NOW(a_dcnt_max, 1'b1, dcnt_q <= CW'(DataDepth), "data count above depth")
  `FSD_ASSERT_NOW(a_rcnt_max, 1'b1, rcnt_q <= RCW'(ReturnDepth), "return count above depth")
  `FSD_ASSERT_NEXT(a_err_keep, ctrl_i.exec && (err_d != fsd_pkg::ERR_OK), (dcnt_q == $past(dcnt_q)) && (rcnt_q == $past(rcnt_q)) && (dwe_q == 3'b000) && (rwe_q == 2'b00), "error changed stacks")

endmodule

`default_nettype wire

// ===== hdl/fsd_ctrl.sv =====
`default_nettype none

module fsd_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output fsd_pkg::fsd_ctrl_t ctrl_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_RD3  = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_WR0  = 4'd6;
  localparam logic [3:0] S_WR1  = 4'd7;
  localparam logic [3:0] S_WR2  = 4'd8;
  localparam logic [3:0] S_TRD  = 4'd9;
  localparam logic [3:0] S_TCAP = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    ctrl_o  = '0;
    ctrl_o.rd_sel = fsd_pkg::RD_TOP0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        ctrl_o.load = in_valid_i;
        if (in_valid_i) state_d = S_RD0;
      end
      S_RD0: state_d = S_RD1;
      S_RD1: begin
        ctrl_o.rd_sel = fsd_pkg::RD_TOP1;
        ctrl_o.cap0   = 1'b1;
        state_d = S_RD2;
      end
      S_RD2: begin
        ctrl_o.rd_sel = fsd_pkg::RD_TOP2;
        ctrl_o.cap1   = 1'b1;
        state_d = S_RD3;
      end
      S_RD3: begin
        ctrl_o.rd_sel = fsd_pkg::RD_PICK;
        ctrl_o.cap2   = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d = S_WR0;
      end
      S_WR0: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_slot = 2'd0;
        state_d = S_WR1;
      end
      S_WR1: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_slot = 2'd1;
        state_d = S_WR2;
      end
      S_WR2: begin
        ctrl_o.wr_en   = 1'b1;
        ctrl_o.wr_slot = 2'd2;
        state_d = S_TRD;
      end
      S_TRD: begin
        ctrl_o.rd_sel = fsd_pkg::RD_VIEW;
        state_d = S_TCAP;
      end
      S_TCAP: begin
        ctrl_o.out_load = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/forth_dual_stack_unit.sv =====
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   cmd_i, push_value_i, push_tag_i
// output    out_valid_o / out_stall_i error_code_o, top_value_o, top_tag_o,
//                                     data_depth_o, return_depth_o
// One transaction at a time: after acceptance the unit steps through three operand
// reads, one indexed read, one execute step, three write slots and one read of the
// new top before the result shows, and the next input is taken only once the result
// is accepted. The steps are serial since each stack memory has a single read port.
// Input stall stays high until the result transaction completes.
// Reset clears both stack depths; stack memories are not cleared.
`default_nettype none

module forth_dual_stack_unit #(
  parameter int unsigned DataStackDepth   = fsd_pkg::DATA_STACK_DEPTH,
  parameter int unsigned ReturnStackDepth = fsd_pkg::RETURN_STACK_DEPTH,
  parameter int unsigned ValueWidth       = fsd_pkg::VALUE_WIDTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic        [fsd_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic signed [fsd_pkg::PV_W-1:0]    push_value_i,
  input  wire logic        [fsd_pkg::TAG_W-1:0]   push_tag_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic             [fsd_pkg::ERR_W-1:0]   error_code_o,
  output logic signed      [fsd_pkg::PV_W-1:0]    top_value_o,
  output logic             [fsd_pkg::TAG_W-1:0]   top_tag_o,
  output logic             [fsd_pkg::DEPTH_W-1:0] data_depth_o,
  output logic             [fsd_pkg::DEPTH_W-1:0] return_depth_o
);

  fsd_pkg::fsd_ctrl_t ctrl;

  fsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  fsd_datapath #(
    .DataDepth   (DataStackDepth),
    .ReturnDepth (ReturnStackDepth),
    .ValueWidth  (ValueWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cmd_i          (cmd_i),
    .push_value_i   (push_value_i),
    .push_tag_i     (push_tag_i),
    .error_code_o   (error_code_o),
    .top_value_o    (top_value_o),
    .top_tag_o      (top_tag_o),
    .data_depth_o   (data_depth_o),
    .return_depth_o (return_depth_o)
  );

endmodule

`default_nettype wire

// ===== bench/forth_dual_stack_unit_tb.sv =====
`default_nettype none

module forth_dual_stack_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DDEPTH = fsd_pkg::DATA_STACK_DEPTH;
  localparam int RDEPTH = fsd_pkg::RETURN_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 600000;

  typedef logic [fsd_pkg::CMD_W-1:0]   cmd_t;
  typedef logic [fsd_pkg::ERR_W-1:0]   err_t;
  typedef logic [fsd_pkg::PV_W-1:0]    pv_t;
  typedef logic [fsd_pkg::TAG_W-1:0]   tag_t;
  typedef logic [fsd_pkg::DEPTH_W-1:0] depth_t;

  typedef struct packed {
    err_t   err;
    pv_t    val;
    tag_t   tag;
    depth_t dd;
    depth_t rd;
  } stack_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cmd_t cmd_i = '0;
  logic signed [fsd_pkg::PV_W-1:0] push_value_i = '0;
  tag_t push_tag_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  err_t error_code_o;
  logic signed [fsd_pkg::PV_W-1:0] top_value_o;
  tag_t top_tag_o;
  depth_t data_depth_o;
  depth_t return_depth_o;

  forth_dual_stack_unit dut (.*);

  pv_t  ds_val [DDEPTH];
  tag_t ds_tag [DDEPTH];
  pv_t  rs_val [RDEPTH];
  tag_t rs_tag [RDEPTH];
  int ds_cnt = 0;
  int rs_cnt = 0;

  stack_view_t views_pending[$];
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit bursty_gaps = 1'b1;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void ds_push(pv_t v, tag_t t);
    ds_val[ds_cnt] = v;
    ds_tag[ds_cnt] = t;
    ds_cnt++;
  endfunction

  function automatic void rs_push(pv_t v, tag_t t);
    rs_val[rs_cnt] = v;
    rs_tag[rs_cnt] = t;
    rs_cnt++;
  endfunction

  function automatic err_t index_check(int below, output int n);
    n = 0;
    if (ds_tag[ds_cnt-1] != fsd_pkg::TAG_INT) return fsd_pkg::ERR_NOTINT;
    if (ds_val[ds_cnt-1][fsd_pkg::PV_W-1]) return fsd_pkg::ERR_NEG;
    if (ds_val[ds_cnt-1] >= pv_t'(below)) return fsd_pkg::ERR_RANGE;
    n = int'(ds_val[ds_cnt-1]);
    return fsd_pkg::ERR_OK;
  endfunction

  function automatic stack_view_t run_word(cmd_t cmd, pv_t pv, tag_t pt);
    stack_view_t r;
    err_t e;
    pv_t va, vb, vc;
    tag_t ta, tb, tc;
    int n, d;
    e = fsd_pkg::ERR_OK;
    d = ds_cnt;
    case (cmd)
      fsd_pkg::CMD_PUSH: begin
        if (d + 1 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else ds_push(pv, pt);
      end
      fsd_pkg::CMD_CLEAR: ds_cnt = 0;
      fsd_pkg::CMD_CLEAR_RS: rs_cnt = 0;
      fsd_pkg::CMD_EMPTY: begin
        if (d + 1 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else ds_push(pv_t'(d == 0), fsd_pkg::TAG_BOOL);
      end
      fsd_pkg::CMD_DEPTH: begin
        if (d + 1 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else ds_push(pv_t'(d), fsd_pkg::TAG_INT);
      end
      fsd_pkg::CMD_DUP: begin
        if (d < 1) e = fsd_pkg::ERR_DUNDER;
        else if (d + 1 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else ds_push(ds_val[d-1], ds_tag[d-1]);
      end
      fsd_pkg::CMD_SWAP: begin
        if (d < 2) e = fsd_pkg::ERR_DUNDER;
        else begin
          va = ds_val[d-1]; ta = ds_tag[d-1];
          ds_val[d-1] = ds_val[d-2]; ds_tag[d-1] = ds_tag[d-2];
          ds_val[d-2] = va; ds_tag[d-2] = ta;
        end
      end
      fsd_pkg::CMD_SWAP_RS: begin
        if (rs_cnt < 2) e = fsd_pkg::ERR_RUNDER;
        else begin
          va = rs_val[rs_cnt-1]; ta = rs_tag[rs_cnt-1];
          rs_val[rs_cnt-1] = rs_val[rs_cnt-2]; rs_tag[rs_cnt-1] = rs_tag[rs_cnt-2];
          rs_val[rs_cnt-2] = va; rs_tag[rs_cnt-2] = ta;
        end
      end
      fsd_pkg::CMD_OVER: begin
        if (d < 2) e = fsd_pkg::ERR_DUNDER;
        else if (d + 1 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else ds_push(ds_val[d-2], ds_tag[d-2]);
      end
      fsd_pkg::CMD_PICK: begin
        if (d < 1) e = fsd_pkg::ERR_DUNDER;
        else begin
          e = index_check(d - 1, n);
          if (e == fsd_pkg::ERR_OK) begin
            ds_val[d-1] = ds_val[d-2-n];
            ds_tag[d-1] = ds_tag[d-2-n];
          end
        end
      end
      fsd_pkg::CMD_REPLACE: begin
        if (d < 2) e = fsd_pkg::ERR_DUNDER;
        else begin
          e = index_check(d - 2, n);
          if (e == fsd_pkg::ERR_OK) begin
            ds_val[d-3-n] = ds_val[d-2];
            ds_tag[d-3-n] = ds_tag[d-2];
            ds_cnt -= 2;
          end
        end
      end
      fsd_pkg::CMD_TWO_DUP: begin
        if (d < 2) e = fsd_pkg::ERR_DUNDER;
        else if (d + 2 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else begin
          va = ds_val[d-2]; ta = ds_tag[d-2];
          vb = ds_val[d-1]; tb = ds_tag[d-1];
          ds_push(va, ta);
          ds_push(vb, tb);
        end
      end
      fsd_pkg::CMD_DROP: if (d < 1) e = fsd_pkg::ERR_DUNDER; else ds_cnt -= 1;
      fsd_pkg::CMD_TWO_DROP: if (d < 2) e = fsd_pkg::ERR_DUNDER; else ds_cnt -= 2;
      fsd_pkg::CMD_THREE_DROP: if (d < 3) e = fsd_pkg::ERR_DUNDER; else ds_cnt -= 3;
      fsd_pkg::CMD_DROP_RS: if (rs_cnt < 1) e = fsd_pkg::ERR_RUNDER; else rs_cnt -= 1;
      fsd_pkg::CMD_TWO_DROP_RS: if (rs_cnt < 2) e = fsd_pkg::ERR_RUNDER; else rs_cnt -= 2;
      fsd_pkg::CMD_ROT, fsd_pkg::CMD_INV_ROT: begin
        if (d < 3) e = fsd_pkg::ERR_DUNDER;
        else begin
          va = ds_val[d-3]; ta = ds_tag[d-3];
          vb = ds_val[d-2]; tb = ds_tag[d-2];
          vc = ds_val[d-1]; tc = ds_tag[d-1];
          if (cmd == fsd_pkg::CMD_ROT) begin
            ds_val[d-3] = vb; ds_tag[d-3] = tb;
            ds_val[d-2] = vc; ds_tag[d-2] = tc;
            ds_val[d-1] = va; ds_tag[d-1] = ta;
          end else begin
            ds_val[d-3] = vc; ds_tag[d-3] = tc;
            ds_val[d-2] = va; ds_tag[d-2] = ta;
            ds_val[d-1] = vb; ds_tag[d-1] = tb;
          end
        end
      end
      fsd_pkg::CMD_TO_R, fsd_pkg::CMD_COPY_TO_R: begin
        if (d < 1) e = fsd_pkg::ERR_DUNDER;
        else if (rs_cnt + 1 > RDEPTH) e = fsd_pkg::ERR_ROVER;
        else begin
          rs_push(ds_val[d-1], ds_tag[d-1]);
          if (cmd == fsd_pkg::CMD_TO_R) ds_cnt--;
        end
      end
      fsd_pkg::CMD_TWO_TO_R: begin
        if (d < 2) e = fsd_pkg::ERR_DUNDER;
        else if (rs_cnt + 2 > RDEPTH) e = fsd_pkg::ERR_ROVER;
        else begin
          rs_push(ds_val[d-1], ds_tag[d-1]);
          rs_push(ds_val[d-2], ds_tag[d-2]);
          ds_cnt -= 2;
        end
      end
      fsd_pkg::CMD_FROM_R, fsd_pkg::CMD_COPY_FROM_R: begin
        if (rs_cnt < 1) e = fsd_pkg::ERR_RUNDER;
        else if (d + 1 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else begin
          ds_push(rs_val[rs_cnt-1], rs_tag[rs_cnt-1]);
          if (cmd == fsd_pkg::CMD_FROM_R) rs_cnt--;
        end
      end
      fsd_pkg::CMD_TWO_FROM_R: begin
        if (rs_cnt < 2) e = fsd_pkg::ERR_RUNDER;
        else if (d + 2 > DDEPTH) e = fsd_pkg::ERR_DOVER;
        else begin
          ds_push(rs_val[rs_cnt-1], rs_tag[rs_cnt-1]);
          ds_push(rs_val[rs_cnt-2], rs_tag[rs_cnt-2]);
          rs_cnt -= 2;
        end
      end
      default: ;
    endcase
    r.err = e;
    r.val = (ds_cnt > 0) ? ds_val[ds_cnt-1] : '0;
    r.tag = (ds_cnt > 0) ? ds_tag[ds_cnt-1] : '0;
    r.dd = depth_t'(ds_cnt);
    r.rd = depth_t'(rs_cnt);
    return r;
  endfunction

  task automatic send_word(cmd_t cmd, pv_t pv = '0, tag_t pt = '0);
    int gap;
    gap = 0;
    if (bursty_gaps && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    push_value_i <= pv;
    push_tag_i <= pt;
    do @(posedge clk_i); while (in_stall_o);
    views_pending.push_back(run_word(cmd, pv, pt));
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (views_pending.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    stack_view_t exp_v, got;
    if (out_valid_o && !out_stall_i) begin
      got = '{error_code_o, top_value_o, top_tag_o, data_depth_o, return_depth_o};
      if (views_pending.size() == 0) begin
        $display("%0t: unexpected result transaction %p", $time, got);
        errors++;
      end else begin
        exp_v = views_pending.pop_front();
        if (got.err != exp_v.err) begin
          $display("%0t: error_code exp %0d got %0d", $time, exp_v.err, got.err);
          errors++;
        end
        if (got.val != exp_v.val) begin
          $display("%0t: top_value exp %h got %h", $time, exp_v.val, got.val);
          errors++;
        end
        if (got.tag != exp_v.tag) begin
          $display("%0t: top_tag exp %0d got %0d", $time, exp_v.tag, got.tag);
          errors++;
        end
        if (got.dd != exp_v.dd) begin
          $display("%0t: data_depth exp %0d got %0d", $time, exp_v.dd, got.dd);
          errors++;
        end
        if (got.rd != exp_v.rd) begin
          $display("%0t: return_depth exp %0d got %0d", $time, exp_v.rd, got.rd);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (cycles % 400 < 150) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic test_empty_words();
    for (int c = 0; c < 32; c++) send_word(cmd_t'(c));
  endtask

  task automatic test_push_extremes();
    send_word(fsd_pkg::CMD_PUSH, 32'h8000_0000, 2'd0);
    send_word(fsd_pkg::CMD_PUSH, 32'h7FFF_FFFF, 2'd3);
    send_word(fsd_pkg::CMD_PUSH, 32'hFFFF_FFFF, fsd_pkg::TAG_BOOL);
    send_word(fsd_pkg::CMD_PUSH, 32'h0, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_EMPTY);
    send_word(fsd_pkg::CMD_DEPTH);
    send_word(fsd_pkg::CMD_CLEAR);
    send_word(fsd_pkg::CMD_EMPTY);
  endtask

  task automatic test_index_errors();
    send_word(fsd_pkg::CMD_CLEAR);
    for (int i = 0; i < 4; i++) begin
      send_word(fsd_pkg::CMD_PUSH, $urandom, tag_t'($urandom_range(0, 3)));
    end
    send_word(fsd_pkg::CMD_PUSH, 32'd1, fsd_pkg::TAG_BOOL);
    send_word(fsd_pkg::CMD_PICK);
    send_word(fsd_pkg::CMD_DROP);
    send_word(fsd_pkg::CMD_PUSH, 32'hFFFF_FFFE, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_PICK);
    send_word(fsd_pkg::CMD_DROP);
    send_word(fsd_pkg::CMD_PUSH, 32'd4, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_PICK);
    send_word(fsd_pkg::CMD_DROP);
    send_word(fsd_pkg::CMD_PUSH, 32'd3, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_PICK);
    send_word(fsd_pkg::CMD_PUSH, 32'd2, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_REPLACE);
    send_word(fsd_pkg::CMD_PUSH, 32'd1, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_REPLACE);
  endtask

  task automatic test_overflow();
    send_word(fsd_pkg::CMD_CLEAR);
    send_word(fsd_pkg::CMD_CLEAR_RS);
    for (int i = 0; i < DDEPTH; i++) begin
      send_word(fsd_pkg::CMD_PUSH, $urandom, tag_t'($urandom_range(0, 3)));
    end
    send_word(fsd_pkg::CMD_PUSH, 32'h5, fsd_pkg::TAG_INT);
    send_word(fsd_pkg::CMD_DUP);
    send_word(fsd_pkg::CMD_TWO_DUP);
    send_word(fsd_pkg::CMD_FROM_R);
    for (int i = 0; i < RDEPTH; i++) send_word(fsd_pkg::CMD_COPY_TO_R);
    send_word(fsd_pkg::CMD_TO_R);
    send_word(fsd_pkg::CMD_TWO_TO_R);
    send_word(fsd_pkg::CMD_TWO_FROM_R);
    send_word(fsd_pkg::CMD_CLEAR);
    send_word(fsd_pkg::CMD_TWO_FROM_R);
    send_word(fsd_pkg::CMD_SWAP_RS);
    send_word(fsd_pkg::CMD_TWO_DROP_RS);
  endtask

  task automatic test_long_hold();
    go_idle();
    hold_left = 300;
    for (int i = 0; i < 20; i++) begin
      send_word(fsd_pkg::CMD_PUSH, $urandom, tag_t'($urandom_range(0, 3)));
    end
    go_idle();
  endtask

  task automatic test_random_words(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      if (i % 300 == 299) bursty_gaps = ~bursty_gaps;
      if (k < 3) begin
        send_word(fsd_pkg::CMD_PUSH, $urandom, tag_t'($urandom_range(0, 3)));
      end else if (k == 3) begin
        send_word(fsd_pkg::CMD_PUSH, pv_t'($urandom_range(0, ds_cnt > 0 ? ds_cnt : 1)),
                  ($urandom_range(0, 7) == 0) ? tag_t'($urandom_range(0, 3))
                                              : fsd_pkg::TAG_INT);
        send_word($urandom_range(0, 1) ? fsd_pkg::CMD_PICK : fsd_pkg::CMD_REPLACE);
        i++;
      end else if (k == 4 && ds_cnt > 24) begin
        send_word(fsd_pkg::CMD_THREE_DROP);
      end else begin
        send_word(cmd_t'($urandom_range(0, 31)), $urandom, tag_t'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_words();
    test_push_extremes();
    test_index_errors();
    test_overflow();
    test_long_hold();
    test_random_words(1400);
    go_idle();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/fsd_pkg.sv
hdl/fsd_ram.sv
hdl/fsd_datapath.sv
hdl/fsd_ctrl.sv
hdl/forth_dual_stack_unit.sv
bench/forth_dual_stack_unit_tb.sv
